// File: rtl/core/ihexld_pkg.sv
// Shared types and constants for the hex record loader.
// Used by the front parser, the back end and the top level.
package ihexld_pkg;

  // Command passed from the parser to the executing back end.
  typedef logic [1:0] op_t;

  localparam op_t OP_LOAD  = 2'd0;  // load the running address
  localparam op_t OP_WRITE = 2'd1;  // emit one data byte at the running address
  localparam op_t OP_END   = 2'd2;  // end of record, update the high-water mark

  localparam int OP_BITS = 2;

  // Depth of the command queue between the parser and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Fixed widths of the stream fields.
  localparam int CH_BITS    = 8;
  localparam int ADDR_OUT   = 16;
  localparam int DATA_OUT   = 8;
  localparam int MARK_OUT   = 17;
  localparam int TDATA_BITS = 48;

  // Result kinds carried on the output tuser.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_END   = 1'b1;

endpackage

// File: rtl/core/ihex_record_loader_top.sv
// Top level of the hex record loader: parser, command queue and back end.
// Depends on ihexld_pkg, ihexld_front, ihexld_queue and ihexld_back.
//
// Usage:
//   The slave stream takes one character of hex text per transaction (tdata).
//   A newline ends the current line. The master stream gives one result per
//   transaction: tuser says whether it is a memory write or a record end.
//   A write carries address, data byte and the high-water mark as it stood
//   before the line; a record end carries the updated high-water mark.
// Timing:
//   One character is taken every cycle while s_tready is high. A result passes
//   through the command queue register and then the output register before it
//   appears. Loading the address needs no output slot.
// Stall:
//   When the receiver holds tready low, the output register holds its result,
//   the queue fills, and s_tready drops once the four queue entries are used.
// Reset:
//   Synchronous reset clears the line state, the running address, the
//   high-water mark, the queue and the output valid flag.
module ihex_record_loader_top #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] wr_addr, [23:16] wr_data, [40:24] high_mark, zero pad
  output logic        m_tuser    // [0] kind
);

  localparam int QW = ihexld_pkg::OP_BITS + ADDR_BITS;

  logic                  accept;
  logic                  push;
  ihexld_pkg::op_t       push_op;
  logic [ADDR_BITS-1:0]  push_value;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [QW-1:0]         q_head;
  ihexld_pkg::op_t       head_op;
  logic [ADDR_BITS-1:0]  head_value;

  logic [ihexld_pkg::ADDR_OUT-1:0] out_addr;
  logic [ihexld_pkg::DATA_OUT-1:0] out_data;
  logic [ihexld_pkg::MARK_OUT-1:0] out_mark;

  // Input transaction.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  ihexld_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .ch        (s_tdata),
    .cmd_push  (push),
    .cmd_op    (push_op),
    .cmd_value (push_value)
  );

  ihexld_queue #(
    .WIDTH (QW),
    .DEPTH (ihexld_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_op, push_value}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_data (q_head)
  );

  assign head_op    = q_head[QW-1:ADDR_BITS];
  assign head_value = q_head[ADDR_BITS-1:0];

  ihexld_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd_op    (head_op),
    .cmd_value (head_value),
    .cmd_pop   (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_addr  (out_addr),
    .out_data  (out_data),
    .out_mark  (out_mark)
  );

  // Result packing, first field in the lowest bits.
  assign m_tdata = {7'b0000000, out_mark, out_data, out_addr};

endmodule

// File: rtl/core/ihexld_front.sv
// Character parser of the hex record loader: tracks the line position and
// turns characters into queue commands. Depends on ihexld_pkg.
module ihexld_front #(
  parameter int ADDR_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 ch,
  output logic                       cmd_push,
  output ihexld_pkg::op_t            cmd_op,
  output logic [ADDR_BITS-1:0]       cmd_value
);

  localparam logic [7:0] NEWLINE  = 8'd10;
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [9:0] POS_MAX  = 10'd1023;
  localparam logic [9:0] DATA_START = 10'd9;
  localparam int SUM_BITS = (ADDR_BITS > 16) ? ADDR_BITS : 16;

  // Hex digit value, -1 for any other character.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h1F;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
    end
    return d[4:0];
  endfunction

  logic [9:0] line_pos;
  logic [4:0] first_nibble;
  logic [8:0] rec_len;
  logic [7:0] addr_hi;
  logic [7:0] bytes_done;

  logic [4:0]          nib;
  logic [8:0]          pair;
  logic [SUM_BITS-1:0] addr_sum;
  logic                len_left;

  // Decode of the current character and its pair value.
  always_comb begin
    nib      = hex_digit(ch);
    pair     = {first_nibble, 4'b0000} + {{4{nib[4]}}, nib};
    addr_sum = SUM_BITS'({addr_hi, 8'h00}) + {{(SUM_BITS-9){pair[8]}}, pair};
    len_left = $signed({2'b00, bytes_done}) < $signed({rec_len[8], rec_len});
  end

  // Command selection for this character.
  always_comb begin
    cmd_push  = 1'b0;
    cmd_op    = ihexld_pkg::OP_WRITE;
    cmd_value = '0;
    if (accept) begin
      if (ch == NEWLINE) begin
        cmd_push = 1'b1;
        cmd_op   = ihexld_pkg::OP_END;
      end else if (line_pos == 10'd6) begin
        cmd_push  = 1'b1;
        cmd_op    = ihexld_pkg::OP_LOAD;
        cmd_value = addr_sum[ADDR_BITS-1:0];
      end else if (line_pos >= DATA_START && !line_pos[0] && len_left) begin
        cmd_push  = 1'b1;
        cmd_op    = ihexld_pkg::OP_WRITE;
        cmd_value = ADDR_BITS'(pair[7:0]);
      end
    end
  end

  // Line state: positions, held digit, length, address and byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos     <= '0;
      first_nibble <= '0;
      rec_len      <= '0;
      addr_hi      <= '0;
      bytes_done   <= '0;
    end else if (accept) begin
      if (ch == NEWLINE) begin
        line_pos     <= '0;
        first_nibble <= '0;
        rec_len      <= '0;
        addr_hi      <= '0;
        bytes_done   <= '0;
      end else begin
        if (line_pos == 10'd1 || line_pos == 10'd3 || line_pos == 10'd5) begin
          first_nibble <= nib;
        end else if (line_pos == 10'd2) begin
          rec_len <= pair;
        end else if (line_pos == 10'd4) begin
          addr_hi <= pair[7:0];
        end else if (line_pos >= DATA_START) begin
          if (line_pos[0]) begin
            first_nibble <= nib;
          end else if (len_left) begin
            bytes_done <= bytes_done + 8'd1;
          end
        end
        if (line_pos != POS_MAX) begin
          line_pos <= line_pos + 10'd1;
        end
      end
    end
  end

endmodule

// File: rtl/core/ihexld_queue.sv
// Small command queue between the parser and the back end.
// Register based, one write and one read port. Depends on nothing else.
module ihexld_queue #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    head;
  logic [PW-1:0]    tail;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign head_data = slots[head];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
      end
      if (pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/ihexld_back.sv
// Back end of the hex record loader: keeps the running address and the
// high-water mark and fills the output register. Depends on ihexld_pkg.
module ihexld_back #(
  parameter int ADDR_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  input  ihexld_pkg::op_t                  cmd_op,
  input  logic [ADDR_BITS-1:0]             cmd_value,
  output logic                             cmd_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_kind,
  output logic [ihexld_pkg::ADDR_OUT-1:0]  out_addr,
  output logic [ihexld_pkg::DATA_OUT-1:0]  out_data,
  output logic [ihexld_pkg::MARK_OUT-1:0]  out_mark
);

  localparam int AW = (ADDR_BITS > ihexld_pkg::ADDR_OUT) ? ADDR_BITS : ihexld_pkg::ADDR_OUT;
  localparam int MW = (ADDR_BITS + 1 > ihexld_pkg::MARK_OUT) ? ADDR_BITS + 1
                                                             : ihexld_pkg::MARK_OUT;
  localparam logic [ADDR_BITS:0] LIMIT = {1'b1, {ADDR_BITS{1'b0}}};

  logic [ADDR_BITS:0] write_ptr;
  logic [ADDR_BITS:0] top_mark;

  logic               slot_free;
  logic [ADDR_BITS:0] end_addr;
  logic [ADDR_BITS:0] new_mark;
  logic [AW-1:0]      addr_wide;
  logic [MW-1:0]      mark_wide;
  logic [MW-1:0]      new_mark_wide;

  // A load needs no output slot; the others wait for a free output register.
  assign slot_free = !out_valid || out_ready;
  assign cmd_pop   = cmd_valid && (cmd_op == ihexld_pkg::OP_LOAD || slot_free);

  // End-of-record mark: the larger of the old mark and the post-record address saturated at the address space.
  always_comb begin
    end_addr      = write_ptr[ADDR_BITS] ? LIMIT : write_ptr;
    new_mark      = (end_addr > top_mark) ? end_addr : top_mark;
    addr_wide     = AW'(write_ptr[ADDR_BITS-1:0]);
    mark_wide     = MW'(top_mark);
    new_mark_wide = MW'(new_mark);
  end

  // Running address and high-water mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      top_mark  <= '0;
    end else if (cmd_pop) begin
      unique case (cmd_op)
        ihexld_pkg::OP_LOAD:  write_ptr <= {1'b0, cmd_value};
        ihexld_pkg::OP_WRITE: write_ptr <= write_ptr + (ADDR_BITS+1)'(1);
        ihexld_pkg::OP_END: begin
          write_ptr <= '0;
          top_mark  <= new_mark;
        end
        default: ;
      endcase
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop && cmd_op != ihexld_pkg::OP_LOAD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_op == ihexld_pkg::OP_WRITE) begin
      out_kind <= ihexld_pkg::KIND_WRITE;
      out_addr <= addr_wide[ihexld_pkg::ADDR_OUT-1:0];
      out_data <= cmd_value[ihexld_pkg::DATA_OUT-1:0];
      out_mark <= mark_wide[ihexld_pkg::MARK_OUT-1:0];
    end else if (cmd_pop && cmd_op == ihexld_pkg::OP_END) begin
      out_kind <= ihexld_pkg::KIND_END;
      out_addr <= '0;
      out_data <= '0;
      out_mark <= new_mark_wide[ihexld_pkg::MARK_OUT-1:0];
    end
  end

endmodule
